FILE: design/rswh_pkg.sv
// Package for the ray and square wall hit test.
// Holds widths, register indexes, wall codes, the CORDIC arc table and shared structs.
// No dependencies.
package rswh_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int POS_BITS      = 16;
    localparam int HALF_W        = 15;
    localparam int MASK_W        = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CORDIC_STAGES = 16;
    localparam int CS_W          = 18;
    localparam int Z_W           = 32;
    localparam int LOC_W         = POS_BITS + 1;
    localparam int HS_W          = HALF_W + 1;
    localparam int PROD_W        = LOC_W + CS_W;
    localparam int SUM_W         = PROD_W + 2;

    localparam logic signed [CS_W-1:0] CORDIC_START = CS_W'(9949);
    localparam logic signed [CS_W-1:0] EPS_Q14      = CS_W'(1);
    localparam logic signed [CS_W-1:0] NEG_EPS_Q14  = -CS_W'(1);

    localparam logic [CFG_IDX_W-1:0] REG_WALL_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_SIDE = 2'd3;

    localparam logic [MASK_W-1:0]          RESET_MASK     = 4'd14;
    localparam logic signed [POS_BITS-1:0] RESET_ORIGIN_X = POS_BITS'(1440);
    localparam logic signed [POS_BITS-1:0] RESET_ORIGIN_Y = POS_BITS'(1440);
    localparam logic [HALF_W-1:0]          RESET_HALF     = 15'd1344;

    localparam logic [2:0] WALL_TOP    = 3'd0;
    localparam logic [2:0] WALL_LEFT   = 3'd1;
    localparam logic [2:0] WALL_RIGHT  = 3'd2;
    localparam logic [2:0] WALL_BOTTOM = 3'd3;
    localparam logic [2:0] WALL_NONE   = 3'd4;

    typedef struct packed {
        logic [MASK_W-1:0]          wall_enable_mask;
        logic signed [POS_BITS-1:0] origin_x;
        logic signed [POS_BITS-1:0] origin_y;
        logic [HALF_W-1:0]          half_side;
    } cfg_t;

    typedef struct packed {
        logic                    valid;
        logic signed [LOC_W-1:0] lx;
        logic signed [LOC_W-1:0] ly;
        logic signed [CS_W-1:0]  c;
        logic signed [CS_W-1:0]  s;
    } loc_item_t;

    function automatic logic signed [Z_W-1:0] arc_angle(input int idx);
        logic signed [Z_W-1:0] a;
        case (idx)
            0:       a = 32'h20000000;
            1:       a = 32'h12E4051D;
            2:       a = 32'h09FB385B;
            3:       a = 32'h051111D4;
            4:       a = 32'h028B0D43;
            5:       a = 32'h0145D7E1;
            6:       a = 32'h00A2F61E;
            7:       a = 32'h00517C55;
            8:       a = 32'h0028BE53;
            9:       a = 32'h00145F2E;
            10:      a = 32'h000A2F98;
            11:      a = 32'h000517CC;
            12:      a = 32'h00028BE6;
            13:      a = 32'h000145F3;
            14:      a = 32'h0000A2F9;
            15:      a = 32'h0000517C;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

FILE: design/rswh_if.sv
// Channel interfaces for the ray and square wall hit test: pose, result and configuration.
// Depends on rswh_pkg.
interface rswh_pose_if import rswh_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [POS_BITS-1:0] pos_x;
    logic signed [POS_BITS-1:0] pos_y;
    logic [ANGLE_BITS-1:0]      heading;

    modport source (output valid, output pos_x, output pos_y, output heading, input ready);
    modport sink (input valid, input pos_x, input pos_y, input heading, output ready);
endinterface

interface rswh_result_if;
    logic       valid;
    logic       ready;
    logic       faces_wall;
    logic [2:0] hit_wall;

    modport source (output valid, output faces_wall, output hit_wall, input ready);
    modport sink (input valid, input faces_wall, input hit_wall, output ready);
endinterface

interface rswh_cfg_if import rswh_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [POS_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/ray_square_wall_hit_test.sv
// Ray and square wall hit test, top level.
// A pose passes the input register, 16-stage CORDIC, fold register and 4-stage wall test.
// Throughput: one pose per cycle unless the result side stalls; all stages advance together.
// A stall on the result side freezes every stage, so no transaction is lost or repeated.
// Reset empties the pipeline and loads the configuration registers with their defaults.
// Depends on rswh_pkg, rswh_if, rswh_cfg, rswh_cordic and rswh_wall.
module ray_square_wall_hit_test
    import rswh_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    rswh_cfg_if.sink      cfg,
    rswh_pose_if.sink     pose,
    rswh_result_if.source result
);

    cfg_t      regs;
    loc_item_t item;
    logic      adv;

    assign pose.ready = adv;

    rswh_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    rswh_cordic u_cordic (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .regs       (regs),
        .pose_valid (pose.valid),
        .pos_x      (pose.pos_x),
        .pos_y      (pose.pos_y),
        .heading    (pose.heading),
        .item       (item)
    );

    rswh_wall u_wall (
        .clk    (clk),
        .rst_n  (rst_n),
        .regs   (regs),
        .item   (item),
        .adv    (adv),
        .result (result)
    );

endmodule

FILE: design/rswh_cfg.sv
// Configuration registers of the ray and square wall hit test.
// Depends on rswh_pkg and rswh_if.
module rswh_cfg
    import rswh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rswh_cfg_if.sink   cfg,
    output cfg_t       regs
);

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.wall_enable_mask <= RESET_MASK;
            regs_reg.origin_x         <= RESET_ORIGIN_X;
            regs_reg.origin_y         <= RESET_ORIGIN_Y;
            regs_reg.half_side        <= RESET_HALF;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_WALL_MASK: regs_reg.wall_enable_mask <= cfg.data[MASK_W-1:0];
                REG_ORIGIN_X:  regs_reg.origin_x         <= cfg.data;
                REG_ORIGIN_Y:  regs_reg.origin_y         <= cfg.data;
                REG_HALF_SIDE: regs_reg.half_side        <= cfg.data[HALF_W-1:0];
                default:       regs_reg                  <= regs_reg;
            endcase
        end
    end

endmodule

FILE: design/rswh_cordic.sv
// Input register, pipelined rotation CORDIC and quadrant fold of the wall hit test.
// Produces the cell-relative position with cosine and sine. Depends on rswh_pkg.
module rswh_cordic
    import rswh_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  cfg_t                       regs,
    input  logic                       pose_valid,
    input  logic signed [POS_BITS-1:0] pos_x,
    input  logic signed [POS_BITS-1:0] pos_y,
    input  logic [ANGLE_BITS-1:0]      heading,
    output loc_item_t                  item
);

    typedef struct packed {
        logic signed [LOC_W-1:0] lx;
        logic signed [LOC_W-1:0] ly;
        logic [1:0]              quad;
        logic signed [Z_W-1:0]   z;
        logic signed [CS_W-1:0]  x;
        logic signed [CS_W-1:0]  y;
    } stage_t;

    logic [CORDIC_STAGES:0] vld_reg;
    stage_t                 stg_reg  [CORDIC_STAGES+1];
    stage_t                 stg_next [CORDIC_STAGES+1];
    logic                   q_vld_reg;
    loc_item_t              q_reg;
    loc_item_t              q_next;

    always_comb
    begin
        logic signed [CS_W-1:0] dx;
        logic signed [CS_W-1:0] dy;
        stg_next[0].lx   = {pos_x[POS_BITS-1], pos_x} - {regs.origin_x[POS_BITS-1], regs.origin_x};
        stg_next[0].ly   = {pos_y[POS_BITS-1], pos_y} - {regs.origin_y[POS_BITS-1], regs.origin_y};
        stg_next[0].quad = heading[ANGLE_BITS-1 -: 2];
        stg_next[0].z    = Z_W'({heading[ANGLE_BITS-3:0], {(32 - ANGLE_BITS){1'b0}}});
        stg_next[0].x    = CORDIC_START;
        stg_next[0].y    = '0;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            dx = stg_reg[i].y >>> i;
            dy = stg_reg[i].x >>> i;
            stg_next[i+1] = stg_reg[i];
            if (stg_reg[i].z >= 0)
            begin
                stg_next[i+1].x = stg_reg[i].x - dx;
                stg_next[i+1].y = stg_reg[i].y + dy;
                stg_next[i+1].z = stg_reg[i].z - arc_angle(i);
            end
            else
            begin
                stg_next[i+1].x = stg_reg[i].x + dx;
                stg_next[i+1].y = stg_reg[i].y - dy;
                stg_next[i+1].z = stg_reg[i].z + arc_angle(i);
            end
        end
    end

    always_comb
    begin
        q_next.valid = vld_reg[CORDIC_STAGES];
        q_next.lx    = stg_reg[CORDIC_STAGES].lx;
        q_next.ly    = stg_reg[CORDIC_STAGES].ly;
        case (stg_reg[CORDIC_STAGES].quad)
            2'd0:
            begin
                q_next.c = stg_reg[CORDIC_STAGES].x;
                q_next.s = stg_reg[CORDIC_STAGES].y;
            end
            2'd1:
            begin
                q_next.c = -stg_reg[CORDIC_STAGES].y;
                q_next.s = stg_reg[CORDIC_STAGES].x;
            end
            2'd2:
            begin
                q_next.c = -stg_reg[CORDIC_STAGES].x;
                q_next.s = -stg_reg[CORDIC_STAGES].y;
            end
            default:
            begin
                q_next.c = stg_reg[CORDIC_STAGES].y;
                q_next.s = -stg_reg[CORDIC_STAGES].x;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            q_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg   <= {vld_reg[CORDIC_STAGES-1:0], pose_valid};
            q_vld_reg <= vld_reg[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i <= CORDIC_STAGES; i++)
            begin
                stg_reg[i] <= stg_next[i];
            end
            q_reg <= q_next;
        end
    end

    always_comb
    begin
        item       = q_reg;
        item.valid = q_vld_reg;
    end

endmodule

FILE: design/rswh_wall.sv
// Wall test pipeline: products, difference, per-wall sums, bound compare and output register.
// Depends on rswh_pkg and rswh_if.
module rswh_wall
    import rswh_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  cfg_t           regs,
    input  loc_item_t      item,
    output logic           adv,
    rswh_result_if.source  result
);

    logic signed [HS_W-1:0]   hs;
    logic                     s1_vld_reg;
    logic                     s2_vld_reg;
    logic                     s3_vld_reg;
    logic                     out_vld_reg;
    logic [3:0]               s1_en_reg;
    logic [3:0]               s2_en_reg;
    logic [3:0]               s3_en_reg;
    logic [3:0]               en_next;
    logic signed [PROD_W-1:0] p1_reg;
    logic signed [PROD_W-1:0] p2_reg;
    logic signed [PROD_W-1:0] p3_reg;
    logic signed [PROD_W-1:0] p4_reg;
    logic signed [SUM_W-1:0]  d_reg;
    logic signed [SUM_W-1:0]  s2_p3_reg;
    logic signed [SUM_W-1:0]  s2_p4_reg;
    logic signed [SUM_W-1:0]  vt_reg;
    logic signed [SUM_W-1:0]  vl_reg;
    logic signed [SUM_W-1:0]  vr_reg;
    logic signed [SUM_W-1:0]  vb_reg;
    logic signed [SUM_W-1:0]  s3_p3_reg;
    logic signed [SUM_W-1:0]  s3_p4_reg;
    logic [3:0]               hit;
    logic                     faces_next;
    logic [2:0]               wall_next;
    logic                     faces_reg;
    logic [2:0]               wall_reg;

    assign hs  = {1'b0, regs.half_side};
    assign adv = !out_vld_reg || result.ready;

    assign en_next[0] = regs.wall_enable_mask[0] && (item.s > EPS_Q14);
    assign en_next[1] = regs.wall_enable_mask[1] && (item.c < NEG_EPS_Q14);
    assign en_next[2] = regs.wall_enable_mask[2] && (item.c > EPS_Q14);
    assign en_next[3] = regs.wall_enable_mask[3] && (item.s < NEG_EPS_Q14);

    assign hit[0] = s3_en_reg[0] && (vt_reg <= s3_p3_reg) && (vt_reg >= -s3_p3_reg);
    assign hit[1] = s3_en_reg[1] && (vl_reg <= -s3_p4_reg) && (vl_reg >= s3_p4_reg);
    assign hit[2] = s3_en_reg[2] && (vr_reg <= s3_p4_reg) && (vr_reg >= -s3_p4_reg);
    assign hit[3] = s3_en_reg[3] && (vb_reg <= -s3_p3_reg) && (vb_reg >= s3_p3_reg);

    always_comb
    begin
        faces_next = 1'b1;
        if (hit[0])
        begin
            wall_next = WALL_TOP;
        end
        else if (hit[1])
        begin
            wall_next = WALL_LEFT;
        end
        else if (hit[2])
        begin
            wall_next = WALL_RIGHT;
        end
        else if (hit[3])
        begin
            wall_next = WALL_BOTTOM;
        end
        else
        begin
            wall_next  = WALL_NONE;
            faces_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg  <= item.valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            out_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg    <= item.lx * item.s;
            p2_reg    <= item.ly * item.c;
            p3_reg    <= hs * item.s;
            p4_reg    <= hs * item.c;
            s1_en_reg <= en_next;

            d_reg     <= SUM_W'(p1_reg) - SUM_W'(p2_reg);
            s2_p3_reg <= SUM_W'(p3_reg);
            s2_p4_reg <= SUM_W'(p4_reg);
            s2_en_reg <= s1_en_reg;

            vt_reg    <= d_reg + s2_p4_reg;
            vb_reg    <= d_reg - s2_p4_reg;
            vl_reg    <= d_reg + s2_p3_reg;
            vr_reg    <= d_reg - s2_p3_reg;
            s3_p3_reg <= s2_p3_reg;
            s3_p4_reg <= s2_p4_reg;
            s3_en_reg <= s2_en_reg;

            faces_reg <= faces_next;
            wall_reg  <= wall_next;
        end
    end

    assign result.valid      = out_vld_reg;
    assign result.faces_wall = faces_reg;
    assign result.hit_wall   = wall_reg;

endmodule
